/* src/urpd_pkg.sv */
// Shared widths, register indexes, reset values and types for the ultrasonic
// range proximity detector. No dependencies.
`default_nettype none

package urpd_pkg;

	// Elapsed-microsecond counter width (default of the top-level parameter)
	localparam int COUNTER_WIDTH_DEF = 16;

	// Field widths
	localparam int PERIOD_W   = 16;
	localparam int TRIGW_W    = 8;
	localparam int DIVISOR_W  = 10;
	localparam int THRESH_W   = 10;
	localparam int DIST_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_WIDTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_US_PER_UNIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_THR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_THR    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUTLIER    = 3'd5;

	// Register reset values
	localparam logic [PERIOD_W-1:0]  PERIOD_RST      = 16'd60000;
	localparam logic [TRIGW_W-1:0]   TRIG_WIDTH_RST  = 8'd10;
	localparam logic [DIVISOR_W-1:0] US_PER_UNIT_RST = 10'd148;
	localparam logic [THRESH_W-1:0]  NEAR_THR_RST    = 10'd13;
	localparam logic [THRESH_W-1:0]  FAR_THR_RST     = 10'd20;
	localparam logic [THRESH_W-1:0]  OUTLIER_RST     = 10'd5;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// Divider status toward the controller
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

/* src/urpd_if.sv */
// Handshake channels of the detector: tick input, result output, config writes.
// Depends on urpd_pkg for payload widths.
`default_nettype none

interface urpd_tick_if;
	logic valid;
	logic ready;
	logic echo_level;
	modport source(output valid, output echo_level, input ready);
	modport sink(input valid, input echo_level, output ready);
endinterface

interface urpd_result_if;
	logic                        valid;
	logic                        ready;
	logic                        trigger_level;
	logic                        event_valid;
	logic                        event_kind;
	logic [urpd_pkg::DIST_W-1:0] distance;
	modport source(output valid, output trigger_level, output event_valid,
		output event_kind, output distance, input ready);
	modport sink(input valid, input trigger_level, input event_valid,
		input event_kind, input distance, output ready);
endinterface

interface urpd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [urpd_pkg::CFG_IDX_W-1:0]  index;
	logic [urpd_pkg::CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/urpd_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on urpd_pkg for the divisor width and the status struct.
`default_nettype none

module urpd_div #(
	parameter int DIVIDEND_W = urpd_pkg::COUNTER_WIDTH_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             start,
	input  wire  [DIVIDEND_W-1:0]           dividend,
	input  wire  [urpd_pkg::DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0]           quotient,
	output urpd_pkg::div_stat_t             stat
);
	import urpd_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    trial_sub;
	logic                  fits;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	assign trial     = {rem_q, quo_q[DIVIDEND_W-1]};
	assign trial_sub = trial - {1'b0, divisor};
	assign fits      = (trial >= {1'b0, divisor});

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

`default_nettype wire

/* src/ultrasonic_range_proximity_detector_top.sv */
// Ultrasonic trigger/echo ranger with near/far hysteresis events.
// An ordinary tick's result is registered at the edge that takes the tick.
// The echo-fall tick's result passes the serial divider and the post state before it is registered.
// One tick per cycle otherwise, while the result channel is free; after an echo fall
// no tick is taken while a division runs or until its result is posted.
// Reset (arst_n, async, active low) restores registers to defaults, phase idle, not near.
`default_nettype none

module ultrasonic_range_proximity_detector_top #(
	parameter int COUNTER_WIDTH = urpd_pkg::COUNTER_WIDTH_DEF
) (
	input  wire           clk,
	input  wire           arst_n,
	urpd_tick_if.sink     tick,
	urpd_result_if.source result,
	urpd_cfg_if.sink      cfg
);
	import urpd_pkg::*;

	localparam int CW = COUNTER_WIDTH;
	localparam int XW = (CW > DIST_W) ? CW : DIST_W;
	localparam logic [CW-1:0] CNT_MAX = '1;

	// Measurement phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_TRIG = 2'd1;
	localparam logic [1:0] PH_WAIT = 2'd2;
	localparam logic [1:0] PH_ECHO = 2'd3;

	// Controller codes
	localparam logic [1:0] CT_RUN  = 2'd0;
	localparam logic [1:0] CT_DIV  = 2'd1;
	localparam logic [1:0] CT_POST = 2'd2;

	logic [PERIOD_W-1:0]  period_q;
	logic [TRIGW_W-1:0]   trig_width_q;
	logic [DIVISOR_W-1:0] us_per_unit_q;
	logic [THRESH_W-1:0]  near_thr_q;
	logic [THRESH_W-1:0]  far_thr_q;
	logic [THRESH_W-1:0]  outlier_q;

	logic [1:0]        phase_q;
	logic [1:0]        ctl_q;
	logic [CW-1:0]     elapsed_q;
	logic [DIST_W-1:0] prev_dist_q;
	logic              object_near_q;

	logic              out_valid_q;
	logic              out_trig_q;
	logic              out_ev_valid_q;
	logic              out_ev_kind_q;
	logic [DIST_W-1:0] out_dist_q;

	logic          tick_acc;
	logic          out_free;
	logic [CW-1:0] elapsed_inc;
	logic [1:0]    phase_nx;
	logic [CW-1:0] elapsed_nx;
	logic          div_go;

	logic [CW-1:0]     quotient;
	div_stat_t         div_stat;
	logic [XW-1:0]     quot_x;
	logic [DIST_W-1:0] dist_val;
	logic [DIST_W-1:0] diff;
	logic              in_window;
	logic              near_fire;
	logic              near_mid;
	logic              far_fire;
	logic              post_ld;

	assign out_free  = !out_valid_q || result.ready;
	assign tick.ready = (ctl_q == CT_RUN) && out_free;
	assign tick_acc  = tick.valid && tick.ready;
	assign cfg.ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q      <= PERIOD_RST;
			trig_width_q  <= TRIG_WIDTH_RST;
			us_per_unit_q <= US_PER_UNIT_RST;
			near_thr_q    <= NEAR_THR_RST;
			far_thr_q     <= FAR_THR_RST;
			outlier_q     <= OUTLIER_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_PERIOD:      period_q      <= cfg.data[PERIOD_W-1:0];
				REG_TRIG_WIDTH:  trig_width_q  <= cfg.data[TRIGW_W-1:0];
				REG_US_PER_UNIT: us_per_unit_q <= cfg.data[DIVISOR_W-1:0];
				REG_NEAR_THR:    near_thr_q    <= cfg.data[THRESH_W-1:0];
				REG_FAR_THR:     far_thr_q     <= cfg.data[THRESH_W-1:0];
				REG_OUTLIER:     outlier_q     <= cfg.data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// Per-tick phase step with saturating elapsed counter
	assign elapsed_inc = (elapsed_q == CNT_MAX) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		phase_nx   = phase_q;
		elapsed_nx = elapsed_inc;
		div_go     = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (XW'(elapsed_inc) >= XW'(period_q)) begin
					elapsed_nx = '0;
					phase_nx   = PH_TRIG;
				end
			end
			PH_TRIG: begin
				if (elapsed_inc >= CW'(trig_width_q))
					phase_nx = PH_WAIT;
			end
			PH_WAIT: begin
				if (tick.echo_level) begin
					elapsed_nx = '0;
					phase_nx   = PH_ECHO;
				end
			end
			PH_ECHO: begin
				if (!tick.echo_level) begin
					phase_nx = PH_IDLE;
					div_go   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Echo width / us_per_unit
	urpd_div #(
		.DIVIDEND_W(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (tick_acc && div_go),
		.dividend (elapsed_inc),
		.divisor  (us_per_unit_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	// Distance, outlier check and near/far hysteresis
	assign quot_x = XW'(quotient);
	always_comb begin
		if (us_per_unit_q == '0)
			dist_val = DIST_MAX;
		else if (quot_x > XW'(DIST_MAX))
			dist_val = DIST_MAX;
		else
			dist_val = quot_x[DIST_W-1:0];
	end

	assign diff      = (dist_val >= prev_dist_q) ? dist_val - prev_dist_q
		: prev_dist_q - dist_val;
	assign in_window = (diff <= DIST_W'(outlier_q));
	assign near_fire = in_window && (dist_val <= DIST_W'(near_thr_q)) && !object_near_q;
	assign near_mid  = object_near_q || near_fire;
	assign far_fire  = in_window && (dist_val >= DIST_W'(far_thr_q)) && near_mid;
	assign post_ld   = (ctl_q == CT_POST) && out_free;

	// Controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= CT_RUN;
		end else begin
			unique case (ctl_q)
				CT_RUN:  if (tick_acc && div_go) ctl_q <= CT_DIV;
				CT_DIV:  if (div_stat.done) ctl_q <= CT_POST;
				CT_POST: if (out_free) ctl_q <= CT_RUN;
				default: ctl_q <= CT_RUN;
			endcase
		end
	end

	// Measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			elapsed_q     <= '0;
			prev_dist_q   <= '0;
			object_near_q <= 1'b0;
		end else begin
			if (tick_acc) begin
				phase_q   <= phase_nx;
				elapsed_q <= elapsed_nx;
			end
			if (post_ld) begin
				prev_dist_q   <= dist_val;
				object_near_q <= near_mid && !far_fire;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (post_ld || (tick_acc && !div_go)) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (post_ld) begin
			out_trig_q     <= 1'b0;
			out_ev_valid_q <= near_fire || far_fire;
			out_ev_kind_q  <= far_fire;
			out_dist_q     <= (near_fire || far_fire) ? dist_val : '0;
		end else if (tick_acc && !div_go) begin
			out_trig_q     <= (phase_nx == PH_TRIG);
			out_ev_valid_q <= 1'b0;
			out_ev_kind_q  <= 1'b0;
			out_dist_q     <= '0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.trigger_level = out_trig_q;
	assign result.event_valid   = out_ev_valid_q;
	assign result.event_kind    = out_ev_kind_q;
	assign result.distance      = out_dist_q;

`ifndef SYNTHESIS
	// No tick is taken while a division is in flight
	a_no_tick_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !tick.ready)
		else $error("tick accepted during division");

	// An echo fall starts the divider on the next edge
	a_div_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_acc && div_go) |=> (div_stat.busy && ctl_q == CT_DIV))
		else $error("divider did not start on echo fall");

	// Events only come with the echo fall, when the trigger is low
	a_event_no_trig: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.event_valid) |-> !result.trigger_level)
		else $error("event reported with trigger high");

	// Proximity state moves only when an event is posted
	a_near_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(object_near_q != $past(object_near_q)) |-> ($past(post_ld)
			&& out_ev_valid_q && (out_ev_kind_q == !object_near_q)))
		else $error("proximity state changed without an event");
`endif

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for ultrasonic_range_proximity_detector_top: random tick
// streams with echo pulses, register rewrites between phases, tick-level predictor.
// Depends on urpd_pkg and the urpd_*_if interfaces from the RTL.
`default_nettype none

module tb_top;
	import urpd_pkg::*;

	localparam int          CNT_W         = COUNTER_WIDTH_DEF;
	localparam int unsigned CNT_MAX       = (1 << CNT_W) - 1;
	localparam int          SETTLE_CYCLES = CNT_W + 8;
	localparam int          RANDOM_TICKS  = 400;
	localparam int          HOLD_AT       = 120;
	localparam int          HOLD_CYCLES   = 200;
	localparam longint      LIMIT_CYCLES  = 4000000;

	// Indexes past the register file; writes there are dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {
		RANGER_IDLE, RANGER_PULSE, RANGER_LISTEN, RANGER_ECHO
	} ranger_phase_t;

	typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_CHOKE} sink_mode_t;

	typedef enum logic {OP_TICK, OP_REG_WRITE} stim_op_t;

	typedef struct {
		stim_op_t                op;
		logic                    echo;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   data;
	} stim_t;

	typedef struct packed {
		logic              trig;
		logic              ev_valid;
		logic              ev_kind;
		logic [DIST_W-1:0] distance;
	} range_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Bench-side drive registers, known from time zero
	logic                  tick_valid = 1'b0;
	logic                  tick_echo  = 1'b0;
	logic                  res_ready  = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	urpd_tick_if   tick_ch();
	urpd_result_if res_ch();
	urpd_cfg_if    cfg_ch();

	assign tick_ch.valid      = tick_valid;
	assign tick_ch.echo_level = tick_echo;
	assign res_ch.ready       = res_ready;
	assign cfg_ch.valid       = cfg_valid;
	assign cfg_ch.index       = cfg_index;
	assign cfg_ch.data        = cfg_data;

	ultrasonic_range_proximity_detector_top dut (
		.clk   (clk),
		.arst_n(arst_n),
		.tick  (tick_ch),
		.result(res_ch),
		.cfg   (cfg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor copy of the ranger registers and state
	logic [PERIOD_W-1:0]  reg_period      = PERIOD_RST;
	logic [TRIGW_W-1:0]   reg_trig_width  = TRIG_WIDTH_RST;
	logic [DIVISOR_W-1:0] reg_us_per_unit = US_PER_UNIT_RST;
	logic [THRESH_W-1:0]  reg_near_thr    = NEAR_THR_RST;
	logic [THRESH_W-1:0]  reg_far_thr     = FAR_THR_RST;
	logic [THRESH_W-1:0]  reg_outlier     = OUTLIER_RST;

	ranger_phase_t rng_phase     = RANGER_IDLE;
	int unsigned   rng_elapsed   = 0;
	int unsigned   rng_prev_dist = 0;
	logic          rng_near      = 1'b0;

	stim_t         pending[$];
	range_result_t expected_results[$];

	logic tick_taken = 1'b0;
	logic cfg_taken  = 1'b0;
	int   ticks_accepted = 0;
	int   mismatches = 0;

	// Generator-side view of the timing registers
	int unsigned gen_period = PERIOD_RST;
	int unsigned gen_trig   = TRIG_WIDTH_RST;
	int          queued_ticks = 0;

	// One microsecond tick of the ranger: counter, phase step, echo-fall evaluation
	function automatic range_result_t ranger_tick(logic echo);
		range_result_t r;
		int unsigned   meas_dist;
		int unsigned   delta;
		r = '0;
		if (rng_elapsed < CNT_MAX)
			rng_elapsed++;
		case (rng_phase)
			RANGER_IDLE: begin
				if (rng_elapsed >= reg_period) begin
					rng_elapsed = 0;
					rng_phase = RANGER_PULSE;
				end
			end
			RANGER_PULSE: begin
				if (rng_elapsed >= reg_trig_width)
					rng_phase = RANGER_LISTEN;
			end
			RANGER_LISTEN: begin
				if (echo) begin
					rng_elapsed = 0;
					rng_phase = RANGER_ECHO;
				end
			end
			default: begin
				if (!echo) begin
					if (reg_us_per_unit == 0)
						meas_dist = DIST_MAX;
					else
						meas_dist = rng_elapsed / reg_us_per_unit;
					if (meas_dist > DIST_MAX)
						meas_dist = DIST_MAX;
					delta = (meas_dist >= rng_prev_dist) ? meas_dist - rng_prev_dist
						: rng_prev_dist - meas_dist;
					if (delta <= reg_outlier) begin
						// near check first; a far hit on the same reading overrides it
						if (meas_dist <= reg_near_thr && !rng_near) begin
							rng_near = 1'b1;
							r.ev_valid = 1'b1;
							r.ev_kind = 1'b0;
							r.distance = DIST_W'(meas_dist);
						end
						if (meas_dist >= reg_far_thr && rng_near) begin
							rng_near = 1'b0;
							r.ev_valid = 1'b1;
							r.ev_kind = 1'b1;
							r.distance = DIST_W'(meas_dist);
						end
					end
					rng_prev_dist = meas_dist;
					rng_phase = RANGER_IDLE;
				end
			end
		endcase
		r.trig = (rng_phase == RANGER_PULSE);
		return r;
	endfunction

	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_PERIOD:      reg_period = data[PERIOD_W-1:0];
			REG_TRIG_WIDTH:  reg_trig_width = data[TRIGW_W-1:0];
			REG_US_PER_UNIT: reg_us_per_unit = data[DIVISOR_W-1:0];
			REG_NEAR_THR:    reg_near_thr = data[THRESH_W-1:0];
			REG_FAR_THR:     reg_far_thr = data[THRESH_W-1:0];
			REG_OUTLIER:     reg_outlier = data[THRESH_W-1:0];
			default: ;
		endcase
	endfunction

	// Register write; bits above the register width carry random junk
	task automatic queue_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		stim_t       s;
		int unsigned w;
		case (idx)
			REG_PERIOD:      w = PERIOD_W;
			REG_TRIG_WIDTH:  w = TRIGW_W;
			REG_US_PER_UNIT: w = DIVISOR_W;
			REG_NEAR_THR, REG_FAR_THR, REG_OUTLIER: w = THRESH_W;
			default:         w = 0;
		endcase
		s.op = OP_REG_WRITE;
		s.echo = 1'b0;
		s.idx = idx;
		if (w == 0)
			s.data = CFG_DATA_W'($urandom);
		else
			s.data = CFG_DATA_W'(value | ($urandom << w));
		if (idx == REG_PERIOD)
			gen_period = value;
		if (idx == REG_TRIG_WIDTH)
			gen_trig = value;
		pending.push_back(s);
	endtask

	task automatic queue_level(logic lvl, int n);
		stim_t s;
		s.op = OP_TICK;
		s.idx = '0;
		s.data = '0;
		s.echo = lvl;
		repeat (n) pending.push_back(s);
		queued_ticks += n;
	endtask

	task automatic queue_noise(int n);
		repeat (n) queue_level(1'($urandom_range(0, 1)), 1);
	endtask

	// Low long enough to pass idle and the pulse from any phase, then an echo of len ticks
	task automatic queue_reading(int len);
		queue_level(1'b0, gen_period + gen_trig + 2 + $urandom_range(0, 2));
		queue_level(1'b1, len);
		queue_level(1'b0, 1);
	endtask

	// Monitor: transaction capture, checking and prediction at the rising edge
	always @(posedge clk) begin : range_monitor
		range_result_t want;
		tick_taken = tick_valid && tick_ch.ready;
		cfg_taken = cfg_valid && cfg_ch.ready;
		if (arst_n) begin
			if (res_ch.valid && res_ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with no expected result pending");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					if (res_ch.trigger_level !== want.trig) begin
						$error("trigger_level: expected %0d, got %0d",
							want.trig, res_ch.trigger_level);
						mismatches++;
					end
					if (res_ch.event_valid !== want.ev_valid) begin
						$error("event_valid: expected %0d, got %0d",
							want.ev_valid, res_ch.event_valid);
						mismatches++;
					end
					if (res_ch.event_kind !== want.ev_kind) begin
						$error("event_kind: expected %0d, got %0d",
							want.ev_kind, res_ch.event_kind);
						mismatches++;
					end
					if (res_ch.distance !== want.distance) begin
						$error("distance: expected %0d, got %0d",
							want.distance, res_ch.distance);
						mismatches++;
					end
				end
			end
			if (tick_taken) begin
				expected_results.push_back(ranger_tick(tick_echo));
				ticks_accepted++;
			end
			if (cfg_taken)
				apply_reg_write(cfg_index, cfg_data);
		end
	end

	// Driver: ticks in bursts with gaps, register writes only once the block is drained
	int burst_left = 0;
	int gap_left = 0;
	int settle_cnt = 0;

	always @(negedge clk) begin : stim_driver
		logic  next_tick_valid;
		logic  next_cfg_valid;
		stim_t head;
		next_tick_valid = tick_valid;
		next_cfg_valid = cfg_valid;
		if (tick_taken)
			next_tick_valid = 1'b0;
		if (cfg_taken)
			next_cfg_valid = 1'b0;
		if (arst_n && !next_tick_valid && !next_cfg_valid && pending.size() != 0) begin
			head = pending[0];
			if (head.op == OP_TICK) begin
				settle_cnt = 0;
				if (gap_left > 0) begin
					gap_left--;
				end else begin
					next_tick_valid = 1'b1;
					tick_echo <= head.echo;
					void'(pending.pop_front());
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 24);
						gap_left = $urandom_range(1, 6);
					end
				end
			end else if (expected_results.size() != 0) begin
				settle_cnt = 0;
			end else if (settle_cnt < SETTLE_CYCLES) begin
				settle_cnt++;
			end else begin
				next_cfg_valid = 1'b1;
				cfg_index <= head.idx;
				cfg_data <= head.data;
				void'(pending.pop_front());
				settle_cnt = 0;
			end
		end
		tick_valid <= next_tick_valid;
		cfg_valid <= next_cfg_valid;
	end

	// Result sink: stall pattern of its own plus one long hold-off
	sink_mode_t sink_mode = SINK_OPEN;
	int         mode_left = 0;
	int         hold_left = 0;
	logic       hold_done = 1'b0;

	always @(negedge clk) begin : result_sink
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (!hold_done && ticks_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				res_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					sink_mode = sink_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (sink_mode)
					SINK_OPEN: res_ready <= 1'b1;
					SINK_COIN: res_ready <= 1'($urandom_range(0, 1));
					default:   res_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Stimulus build, reset, end of run
	initial begin : run_control
		int start_ticks;
		int unsigned upu;
		int unsigned near_v;
		int unsigned far_v;
		int unsigned target;
		int len;

		// defaults: long period keeps the block idle
		queue_noise(20);

		queue_reg(REG_PERIOD, 4);
		queue_reg(REG_TRIG_WIDTH, 2);
		queue_reg(REG_US_PER_UNIT, 1);
		queue_reg(REG_NEAR_THR, 3);
		queue_reg(REG_FAR_THR, 6);
		queue_reg(REG_OUTLIER, 1023);
		queue_reg(REG_SPARE_LO, 0);
		queue_reg(REG_SPARE_HI, 0);
		queue_reading(2);
		queue_reading(8);
		queue_reading(3);
		queue_reading(6);

		// largest divisor: distance collapses to zero
		queue_reg(REG_US_PER_UNIT, 1023);
		queue_reading(5);

		// near at or above far: one reading crosses both, far wins
		queue_reg(REG_NEAR_THR, 1023);
		queue_reg(REG_FAR_THR, 0);
		queue_reg(REG_OUTLIER, 0);
		queue_reading(7);
		queue_reading(2);

		// zero window rejects any change
		queue_reg(REG_US_PER_UNIT, 1);
		queue_reading(5);

		// zero period and zero pulse width
		queue_reg(REG_PERIOD, 0);
		queue_reg(REG_TRIG_WIDTH, 0);
		queue_reg(REG_OUTLIER, 2);
		queue_reading(3);
		queue_reading(4);

		queue_reg(REG_TRIG_WIDTH, 255);
		queue_reg(REG_PERIOD, 1);
		queue_reading(1);

		// longest period: no pulse within this stretch
		queue_reg(REG_PERIOD, 65535);
		queue_noise(40);

		// zero divisor, then a longer echo checked against the saturated reading
		queue_reg(REG_PERIOD, 3);
		queue_reg(REG_TRIG_WIDTH, 1);
		queue_reg(REG_US_PER_UNIT, 1);
		queue_reg(REG_NEAR_THR, 2);
		queue_reg(REG_FAR_THR, 1023);
		queue_reg(REG_OUTLIER, 1023);
		queue_reading(1);
		queue_reg(REG_US_PER_UNIT, 0);
		queue_reading(3);
		queue_reg(REG_US_PER_UNIT, 1);
		queue_reading(30);

		// random phases: new settings, mostly well-formed readings around the thresholds
		start_ticks = queued_ticks;
		while (queued_ticks - start_ticks < RANDOM_TICKS) begin
			case ($urandom_range(0, 19)) inside
				[0:13]:  upu = $urandom_range(1, 3);
				[14:16]: upu = $urandom_range(4, 20);
				[17:18]: upu = 0;
				default: upu = 1023;
			endcase
			near_v = $urandom_range(0, 8);
			far_v = $urandom_range(0, 1) ? near_v + $urandom_range(0, 6)
				: $urandom_range(0, 8);
			queue_reg(REG_PERIOD, $urandom_range(0, 12));
			queue_reg(REG_TRIG_WIDTH, ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
				: $urandom_range(0, 6));
			queue_reg(REG_US_PER_UNIT, upu);
			queue_reg(REG_NEAR_THR, near_v);
			queue_reg(REG_FAR_THR, far_v);
			queue_reg(REG_OUTLIER, ($urandom_range(0, 3) == 0) ? 1023
				: $urandom_range(0, 6));
			repeat ($urandom_range(4, 10)) begin
				if ($urandom_range(0, 6) == 0) begin
					queue_noise($urandom_range(3, 12));
				end else begin
					target = $urandom_range(0, ((near_v > far_v) ? near_v : far_v) + 4);
					if (upu == 0 || upu > 20)
						len = $urandom_range(1, 30);
					else
						len = target * upu + $urandom_range(0, upu - 1);
					if (len < 1)
						len = 1;
					queue_reading(len);
				end
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do @(posedge clk); while (pending.size() != 0 || tick_valid || cfg_valid);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#(LIMIT_CYCLES * 12);
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
src/urpd_pkg.sv
src/urpd_if.sv
src/urpd_div.sv
src/ultrasonic_range_proximity_detector_top.sv
bench/tb_top.sv
